>>> hdl/glc_pkg.sv
// shared constants and controller/datapath link types for the growth curve lag extractor
// no dependencies

package glc_pkg;

    localparam int LAG_W            = 19;
    localparam int VAL_W            = 24;
    localparam int DEF_MAX_SAMPLES  = 1024;
    localparam int DEF_SAMPLE_BITS  = 24;
    localparam int DEF_FRAC_BITS    = 8;

    // commands from controller to datapath
    typedef struct packed {
        logic upd;        // take one sample into the running state
        logic div_load;   // load divider operands from the curve state
        logic div_step;   // one restoring division step
        logic fix;        // floor correction and sign of quotient
        logic fin;        // write result register and clear curve state
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic div_last;   // current step is the final divider step
        logic out_free;   // result register can take a new result
    } t_sts;

endpackage

>>> hdl/glc_ctrl.sv
// controller state machine for the growth curve lag extractor
// depends on glc_pkg

module glc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    output logic          o_in_ready,
    input  glc_pkg::t_sts i_sts,
    output glc_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_STREAM,
        S_LOAD,
        S_DIV,
        S_FIX,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_STREAM: begin
                o_cmd.upd = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                // hold until the previous result has gone
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_STREAM;
                end
            end
            default: begin
                n_state = S_STREAM;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_STREAM;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_STREAM);

endmodule

>>> hdl/glc_dp.sv
// datapath: running curve state, shared restoring divider, lag clamp and result register
// depends on glc_pkg

module glc_dp #(
    parameter int MAX_SAMPLES = glc_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = glc_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = glc_pkg::DEF_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  glc_pkg::t_cmd                   i_cmd,
    output glc_pkg::t_sts                   o_sts,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [glc_pkg::LAG_W-1:0]       o_lag_time,
    output logic [glc_pkg::VAL_W-1:0]       o_max_rise,
    output logic [glc_pkg::VAL_W-1:0]       o_max_rate,
    output logic                            o_overflowed
);

    localparam int SW1  = SAMPLE_BITS + 1;
    localparam int NW   = SW1 + FRAC_BITS;
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int PW   = $clog2(MAX_SAMPLES);
    localparam int DCW  = $clog2(NW + 1);
    localparam int LGW0 = NW + CW + 2;
    localparam int LGW  = (LGW0 > glc_pkg::LAG_W) ? LGW0 : glc_pkg::LAG_W;
    localparam int EW   = (SW1 > glc_pkg::VAL_W) ? SW1 : glc_pkg::VAL_W;

    // curve state
    logic signed [SAMPLE_BITS-1:0] r_first;
    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic signed [SAMPLE_BITS-1:0] r_peak;
    logic signed [SAMPLE_BITS-1:0] r_level;
    logic signed [SW1-1:0]         r_sstep;
    logic signed [SW1-1:0]         r_rate;
    logic [PW-1:0]                 r_pos;
    logic [CW-1:0]                 r_count;
    logic                          r_ovf;

    // divider
    logic [NW-1:0]                 r_num;
    logic [SW1-1:0]                r_den;
    logic [SW1-1:0]                r_rem;
    logic                          r_neg;
    logic                          r_skip;
    logic [DCW-1:0]                r_div_cnt;
    logic signed [NW:0]            r_q;

    // result register
    logic                          r_out_valid;
    logic [glc_pkg::LAG_W-1:0]     r_lag;
    logic [glc_pkg::VAL_W-1:0]     r_rise;
    logic [glc_pkg::VAL_W-1:0]     r_rate_out;
    logic                          r_ovf_out;

    logic signed [SW1-1:0]         w_step;
    logic signed [NW-1:0]          w_num_s;
    logic [NW-1:0]                 w_num_mag;
    logic [SW1-1:0]                w_den_mag;
    logic [SW1:0]                  w_rem_sh;
    logic [SW1:0]                  w_rem_sub;
    logic                          w_ge;
    logic [NW:0]                   w_qm_inc;
    logic signed [LGW-1:0]         w_pos_sc;
    logic signed [LGW-1:0]         w_lim;
    logic signed [LGW-1:0]         w_lag;
    logic signed [LGW-1:0]         w_lag_cl;
    logic signed [SW1-1:0]         w_rise;
    logic [EW-1:0]                 w_rise_ext;
    logic [EW-1:0]                 w_rate_ext;

    assign w_step    = SW1'(i_sample) - SW1'(r_prev);
    assign w_num_s   = NW'(SW1'(r_first) - SW1'(r_level)) <<< FRAC_BITS;
    assign w_num_mag = w_num_s[NW-1] ? -w_num_s : w_num_s;
    assign w_den_mag = r_sstep[SW1-1] ? -r_sstep : r_sstep;

    assign w_rem_sh  = {r_rem, r_num[NW-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    // floor for a negative quotient with a remainder
    assign w_qm_inc  = {1'b0, r_num} + (NW + 1)'(r_rem != '0);

    assign w_pos_sc  = $signed(LGW'(r_pos) << FRAC_BITS);
    assign w_lim     = $signed(LGW'(r_count) << FRAC_BITS);
    assign w_lag     = w_pos_sc + LGW'(r_q);

    always_comb begin
        priority if (r_skip || (w_lag <= 0)) begin
            w_lag_cl = '0;
        end else if (w_lag >= w_lim) begin
            w_lag_cl = w_lim;
        end else begin
            w_lag_cl = w_lag;
        end
    end

    assign w_rise     = SW1'(r_peak) - SW1'(r_first);
    assign w_rise_ext = EW'(w_rise);
    assign w_rate_ext = EW'(r_rate);

    // curve state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.fin) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.upd) begin
            priority if (r_count == CW'(MAX_SAMPLES)) begin
                r_ovf <= 1'b1;
            end else if (r_count == '0) begin
                r_first <= i_sample;
                r_prev  <= i_sample;
                r_peak  <= i_sample;
                r_level <= i_sample;
                r_sstep <= '0;
                r_pos   <= '0;
                r_rate  <= '0;
                r_count <= CW'(1);
            end else begin
                // first position wins on a tie
                if ((r_count == CW'(1)) || (w_step > r_sstep)) begin
                    r_sstep <= w_step;
                    r_pos   <= PW'(r_count - CW'(1));
                    r_level <= r_prev;
                end
                if (w_step > r_rate) begin
                    r_rate <= w_step;
                end
                if (i_sample > r_peak) begin
                    r_peak <= i_sample;
                end
                r_prev  <= i_sample;
                r_count <= r_count + CW'(1);
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_load) begin
            r_num     <= w_num_mag;
            r_den     <= w_den_mag;
            r_rem     <= '0;
            r_neg     <= w_num_s[NW-1] ^ r_sstep[SW1-1];
            r_skip    <= (r_sstep == '0) || (r_count < CW'(2));
            r_div_cnt <= DCW'(NW);
        end else if (i_cmd.div_step) begin
            r_num     <= {r_num[NW-2:0], w_ge};
            r_rem     <= w_ge ? w_rem_sub[SW1-1:0] : w_rem_sh[SW1-1:0];
            r_div_cnt <= r_div_cnt - DCW'(1);
        end else if (i_cmd.fix) begin
            r_q <= r_neg ? -$signed(w_qm_inc) : $signed({1'b0, r_num});
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
            r_lag       <= w_lag_cl[glc_pkg::LAG_W-1:0];
            r_rise      <= w_rise_ext[glc_pkg::VAL_W-1:0];
            r_rate_out  <= w_rate_ext[glc_pkg::VAL_W-1:0];
            r_ovf_out   <= r_ovf;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.div_last = (r_div_cnt == DCW'(1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_lag_time   = r_lag;
    assign o_max_rise   = r_rise;
    assign o_max_rate   = r_rate_out;
    assign o_overflowed = r_ovf_out;

endmodule

>>> hdl/growth_curve_lag_extractor_core.sv
// top level of the growth curve lag extractor: controller plus datapath
// depends on glc_pkg, glc_ctrl, glc_dp
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_sample, i_last
//  out     | o_out_valid | i_out_ready | o_lag_time, o_max_rise, o_max_rate, o_overflowed
//
// samples are taken one per cycle while a curve streams in
// after the sample marked last, input stalls for operand load, the shared divider
// producing one quotient bit per cycle, sign fix and result write; longer if the
// previous result is still held at the output
// synchronous active-low reset clears control state only; no clearing pass

module growth_curve_lag_extractor_core #(
    parameter int MAX_SAMPLES = glc_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = glc_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = glc_pkg::DEF_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample,
    input  logic                            i_last,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [glc_pkg::LAG_W-1:0]       o_lag_time,
    output logic [glc_pkg::VAL_W-1:0]       o_max_rise,
    output logic [glc_pkg::VAL_W-1:0]       o_max_rate,
    output logic                            o_overflowed
);

    glc_pkg::t_cmd w_cmd;
    glc_pkg::t_sts w_sts;

    glc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_last),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    glc_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_sample     (i_sample),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_lag_time   (o_lag_time),
        .o_max_rise   (o_max_rise),
        .o_max_rate   (o_max_rate),
        .o_overflowed (o_overflowed)
    );

    // at most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.upd, w_cmd.div_load, w_cmd.div_step, w_cmd.fix, w_cmd.fin}))
        else $error("more than one datapath command at once");

    // a result is never written over one still waiting
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fin |-> (!o_out_valid || i_out_ready))
        else $error("result written while output register busy");

    // the last sample of a curve closes the input until the result is made
    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last) |=> !o_in_ready)
        else $error("input still open after last sample");

endmodule
